FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the burst length estimator modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define BLE_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define BLE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ble_pkg.sv
// ----------------------------------------------------------------------------
// ble_pkg
// Types and constants of the burst length estimator.
// ----------------------------------------------------------------------------
package ble_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COUNT_BITS     = 32;
    localparam int MAX_BURSTS     = 20;
    localparam int BURST_BITS     = 5;
    localparam int FRAC_BITS      = 16;
    localparam int MEAN_BITS      = COUNT_BITS + 8;
    localparam int RANGE_BITS     = SAMPLE_BITS + 1;
    localparam int THR_BITS       = SAMPLE_BITS + 2;
    localparam int PROD_BITS      = 2 * RANGE_BITS;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [2:0] OP_RANGE = 3'd0;
    localparam logic [2:0] OP_BEGIN = 3'd1;
    localparam logic [2:0] OP_RUN   = 3'd2;
    localparam logic [2:0] OP_END   = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_FRACTION  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_FRACTION = 2'd1;

    localparam logic [FRAC_BITS-1:0] LOW_FRACTION_RESET  = 16'd13107;
    localparam logic [FRAC_BITS-1:0] HIGH_FRACTION_RESET = 16'd52429;

    typedef enum logic [2:0] {
        CMD_RANGE,
        CMD_BEGIN,
        CMD_RUN,
        CMD_END,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                      kind;
        logic signed [SAMPLE_BITS-1:0]  sample;
    } cmd_t;

    typedef struct packed {
        logic [2:0]                     opcode;
        logic signed [SAMPLE_BITS-1:0]  sample;
    } in_item_t;

    typedef struct packed {
        logic [MEAN_BITS-1:0]           mean_length;
        logic [BURST_BITS-1:0]          burst_count;
        logic                           no_bursts;
        logic signed [SAMPLE_BITS-1:0]  range_min;
        logic signed [SAMPLE_BITS-1:0]  range_max;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_THR_HI,
        ST_DIV,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        logic pop;
        logic div_start;
        logic load;
    } back_ctl_t;

endpackage

FILE: sv/ble_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ble_cmd_fifo
// Short command queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ble_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           enq,
    input  ble_pkg::cmd_t  enq_cmd,
    output logic           full,
    input  logic           deq,
    output ble_pkg::cmd_t  deq_cmd,
    output logic           empty
);

    localparam int PTR_BITS = $clog2(ble_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(ble_pkg::QUEUE_DEPTH + 1);

    ble_pkg::cmd_t        slot_reg [ble_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg;
    logic [PTR_BITS-1:0]  rd_ptr_reg;
    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  count_next;

    assign full    = (count_reg == CNT_BITS'(ble_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign deq_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (enq && !(deq && !empty))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!enq && deq && !empty)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (enq)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (deq && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            slot_reg[wr_ptr_reg] <= enq_cmd;
        end
    end

    `BLE_ASSERT(a_no_enq_when_full, clk, rst_n, !(enq && full), "enqueue into full queue")

endmodule

FILE: sv/ble_front.sv
// ----------------------------------------------------------------------------
// ble_front
// Accepts input transactions, decodes the opcode and queues valid commands.
// ----------------------------------------------------------------------------
module ble_front (
    input  logic               push,
    input  ble_pkg::in_item_t  in_item,
    input  logic               q_full,
    output logic               enq,
    output ble_pkg::cmd_t      enq_cmd
);

    logic known_op;

    always_comb
    begin
        known_op       = 1'b1;
        enq_cmd.sample = in_item.sample;
        enq_cmd.kind   = ble_pkg::CMD_RANGE;
        unique case (in_item.opcode)
            ble_pkg::OP_RANGE: enq_cmd.kind = ble_pkg::CMD_RANGE;
            ble_pkg::OP_BEGIN: enq_cmd.kind = ble_pkg::CMD_BEGIN;
            ble_pkg::OP_RUN:   enq_cmd.kind = ble_pkg::CMD_RUN;
            ble_pkg::OP_END:   enq_cmd.kind = ble_pkg::CMD_END;
            ble_pkg::OP_CLEAR: enq_cmd.kind = ble_pkg::CMD_CLEAR;
            default:           known_op     = 1'b0;
        endcase
    end

    // unused opcodes are accepted and dropped
    assign enq = push && !q_full && known_op;

endmodule

FILE: sv/ble_div.sv
// ----------------------------------------------------------------------------
// ble_div
// Restoring divider, one quotient bit per cycle, for the mean burst length.
// ----------------------------------------------------------------------------
module ble_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ble_pkg::MEAN_BITS-1:0]     dividend,
    input  logic [ble_pkg::BURST_BITS-1:0]    divisor,
    output logic                              done,
    output logic [ble_pkg::MEAN_BITS-1:0]     quotient
);

    localparam int STEP_BITS = $clog2(ble_pkg::MEAN_BITS);

    logic                              busy_reg;
    logic                              done_reg;
    logic [STEP_BITS-1:0]              step_reg;
    logic [ble_pkg::MEAN_BITS-1:0]     quo_reg;
    logic [ble_pkg::BURST_BITS-1:0]    rem_reg;
    logic [ble_pkg::BURST_BITS-1:0]    div_reg;
    logic [ble_pkg::BURST_BITS:0]      rem_shift;
    logic                              fits;
    logic [ble_pkg::BURST_BITS:0]      rem_sub;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[ble_pkg::MEAN_BITS-1]};
        fits      = (rem_shift >= {1'b0, div_reg});
        rem_sub   = rem_shift - {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_BITS'(ble_pkg::MEAN_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[ble_pkg::MEAN_BITS-2:0], fits};
            rem_reg <= fits ? rem_sub[ble_pkg::BURST_BITS-1:0]
                            : rem_shift[ble_pkg::BURST_BITS-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/ble_back.sv
// ----------------------------------------------------------------------------
// ble_back
// Executes queued commands: range tracking, thresholds, burst detection,
// mean computation and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ble_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [ble_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [ble_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  q_empty,
    input  ble_pkg::cmd_t                         q_cmd,
    output logic                                  q_deq,
    input  logic                                  res_pop,
    output logic                                  res_valid,
    output ble_pkg::out_item_t                    res_item
);

    localparam int SB = ble_pkg::SAMPLE_BITS;
    localparam int CB = ble_pkg::COUNT_BITS;
    localparam int BB = ble_pkg::BURST_BITS;
    localparam int TB = ble_pkg::THR_BITS;

    localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

    ble_pkg::back_state_t  state_reg;
    ble_pkg::back_state_t  state_next;
    ble_pkg::back_ctl_t    ctl;

    logic [ble_pkg::FRAC_BITS-1:0]            low_frac_reg;
    logic [ble_pkg::FRAC_BITS-1:0]            high_frac_reg;
    logic signed [SB-1:0]                     min_reg;
    logic signed [SB-1:0]                     max_reg;
    logic signed [TB-1:0]                     lower_reg;
    logic signed [TB-1:0]                     upper_reg;
    logic                                     in_burst_reg;
    logic [CB-1:0]                            cur_len_reg;
    logic [CB-1:0]                            total_reg;
    logic [BB-1:0]                            bursts_reg;
    logic signed [ble_pkg::RANGE_BITS-1:0]    range_reg;
    logic signed [ble_pkg::PROD_BITS-1:0]     prod_reg;
    logic                                     res_valid_reg;
    ble_pkg::out_item_t                       res_reg;

    logic signed [TB-1:0]                     run_s;
    logic [CB:0]                              total_sum;
    logic signed [TB-1:0]                     thr_base;
    logic signed [TB-1:0]                     thr_value;
    logic                                     div_done;
    logic [ble_pkg::MEAN_BITS-1:0]            div_quo;

    ble_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend ({total_reg, 8'd0}),
        .divisor  (bursts_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        run_s     = {{(TB-SB){q_cmd.sample[SB-1]}}, q_cmd.sample};
        total_sum = {1'b0, total_reg} + {1'b0, cur_len_reg};
        thr_base  = {{(TB-SB){min_reg[SB-1]}}, min_reg};
        // arithmetic shift by 16 floors toward minus infinity
        thr_value = thr_base + prod_reg[ble_pkg::PROD_BITS-1 -: TB];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ble_pkg::ST_IDLE:
            begin
                if (!q_empty && q_cmd.kind == ble_pkg::CMD_BEGIN)
                begin
                    state_next = ble_pkg::ST_MUL_LO;
                end
                else if (!q_empty && q_cmd.kind == ble_pkg::CMD_END)
                begin
                    state_next = (bursts_reg == '0) ? ble_pkg::ST_OUT : ble_pkg::ST_DIV;
                end
            end
            ble_pkg::ST_MUL_LO: state_next = ble_pkg::ST_MUL_HI;
            ble_pkg::ST_MUL_HI: state_next = ble_pkg::ST_THR_HI;
            ble_pkg::ST_THR_HI: state_next = ble_pkg::ST_IDLE;
            ble_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ble_pkg::ST_OUT;
                end
            end
            ble_pkg::ST_OUT:
            begin
                if (!res_valid_reg || res_pop)
                begin
                    state_next = ble_pkg::ST_IDLE;
                end
            end
            default: state_next = ble_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.pop       = (state_reg == ble_pkg::ST_IDLE) && !q_empty;
        ctl.div_start = ctl.pop && (q_cmd.kind == ble_pkg::CMD_END) && (bursts_reg != '0);
        ctl.load      = (state_reg == ble_pkg::ST_OUT) && (!res_valid_reg || res_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ble_pkg::ST_IDLE;
            low_frac_reg  <= ble_pkg::LOW_FRACTION_RESET;
            high_frac_reg <= ble_pkg::HIGH_FRACTION_RESET;
            min_reg       <= SAMPLE_MAX;
            max_reg       <= SAMPLE_MIN;
            lower_reg     <= '0;
            upper_reg     <= '0;
            in_burst_reg  <= 1'b0;
            cur_len_reg   <= '0;
            total_reg     <= '0;
            bursts_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write && cfg_index == ble_pkg::REG_LOW_FRACTION)
            begin
                low_frac_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == ble_pkg::REG_HIGH_FRACTION)
            begin
                high_frac_reg <= cfg_data;
            end

            if (ctl.pop)
            begin
                unique case (q_cmd.kind)
                    ble_pkg::CMD_RANGE:
                    begin
                        if (q_cmd.sample > max_reg)
                        begin
                            max_reg <= q_cmd.sample;
                        end
                        if (q_cmd.sample < min_reg)
                        begin
                            min_reg <= q_cmd.sample;
                        end
                    end
                    ble_pkg::CMD_CLEAR:
                    begin
                        min_reg <= SAMPLE_MAX;
                        max_reg <= SAMPLE_MIN;
                    end
                    ble_pkg::CMD_BEGIN:
                    begin
                        in_burst_reg <= 1'b0;
                        cur_len_reg  <= '0;
                        total_reg    <= '0;
                        bursts_reg   <= '0;
                    end
                    ble_pkg::CMD_RUN:
                    begin
                        if (bursts_reg < BB'(ble_pkg::MAX_BURSTS))
                        begin
                            priority if (!in_burst_reg && run_s > upper_reg)
                            begin
                                in_burst_reg <= 1'b1;
                                cur_len_reg  <= CB'(1);
                            end
                            else if (in_burst_reg && run_s < lower_reg)
                            begin
                                in_burst_reg <= 1'b0;
                                bursts_reg   <= bursts_reg + 1'b1;
                                total_reg    <= total_sum[CB] ? '1 : total_sum[CB-1:0];
                            end
                            else if (in_burst_reg && cur_len_reg != '1)
                            begin
                                cur_len_reg <= cur_len_reg + 1'b1;
                            end
                        end
                    end
                    ble_pkg::CMD_END:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ble_pkg::ST_MUL_HI)
            begin
                lower_reg <= thr_value;
            end
            if (state_reg == ble_pkg::ST_THR_HI)
            begin
                upper_reg <= thr_value;
            end

            if (ctl.load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.pop && q_cmd.kind == ble_pkg::CMD_BEGIN)
        begin
            range_reg <= {max_reg[SB-1], max_reg} - {min_reg[SB-1], min_reg};
        end
        if (state_reg == ble_pkg::ST_MUL_LO)
        begin
            prod_reg <= $signed({1'b0, low_frac_reg}) * range_reg;
        end
        else if (state_reg == ble_pkg::ST_MUL_HI)
        begin
            prod_reg <= $signed({1'b0, high_frac_reg}) * range_reg;
        end
        if (ctl.load)
        begin
            res_reg.mean_length <= (bursts_reg == '0) ? '0 : div_quo;
            res_reg.burst_count <= bursts_reg;
            res_reg.no_bursts   <= (bursts_reg == '0);
            res_reg.range_min   <= min_reg;
            res_reg.range_max   <= max_reg;
        end
    end

    assign q_deq     = ctl.pop;
    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

    `BLE_ASSERT(a_bursts_bounded, clk, rst_n, bursts_reg <= BB'(ble_pkg::MAX_BURSTS), "burst count over limit")
    `BLE_ASSERT_NEXT(a_div_to_out, clk, rst_n, state_reg == ble_pkg::ST_DIV && div_done, state_reg == ble_pkg::ST_OUT, "divider result not taken")

endmodule

FILE: sv/burst_length_estimator.sv
// ----------------------------------------------------------------------------
// burst_length_estimator
// Hysteresis burst detector over a stream of Q3.12 samples; reports the mean
// burst length, burst count and tracked range at each end-run command.
// ----------------------------------------------------------------------------
// Input: push an item while full is low; opcode selects range sample, begin
// run, run sample, end run or clear range. Unused opcodes are taken and
// dropped. Items enter a four-entry command queue.
// Output: while empty is low the result is on out_item; pop takes it.
// Config: cfg_write with cfg_index 0 (low fraction) or 1 (high fraction),
// only while no transaction is in flight.
// Throughput: the back end takes range, clear and run samples one per cycle
// while it is idle. Begin run passes twice through the threshold multiplier
// (states MUL_LO, MUL_HI, THR_HI). End run goes straight to state OUT with
// no bursts, otherwise first to state DIV for the one-bit-per-cycle 40-bit
// divider. Result: state OUT loads the result register onto the outputs once
// the receiver has taken the previous result. A stalled receiver holds the
// result register; the back end then waits at the next end run while the
// queue keeps filling until full.
// Reset: queue and result register empty, range and counters at reset values.
// ----------------------------------------------------------------------------
module burst_length_estimator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  ble_pkg::in_item_t                     in_item,
    output logic                                  empty,
    input  logic                                  pop,
    output ble_pkg::out_item_t                    out_item,
    input  logic                                  cfg_write,
    input  logic [ble_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [ble_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    logic           q_full;
    logic           q_empty;
    logic           enq;
    logic           deq;
    logic           res_valid;
    ble_pkg::cmd_t  enq_cmd;
    ble_pkg::cmd_t  deq_cmd;

    ble_front u_front (
        .push    (push),
        .in_item (in_item),
        .q_full  (q_full),
        .enq     (enq),
        .enq_cmd (enq_cmd)
    );

    ble_cmd_fifo u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .enq     (enq),
        .enq_cmd (enq_cmd),
        .full    (q_full),
        .deq     (deq),
        .deq_cmd (deq_cmd),
        .empty   (q_empty)
    );

    ble_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_cmd     (deq_cmd),
        .q_deq     (deq),
        .res_pop   (pop && res_valid),
        .res_valid (res_valid),
        .res_item  (out_item)
    );

    assign full  = q_full;
    assign empty = !res_valid;

endmodule

FILE: dv/tb_burst_length_estimator.sv
// ----------------------------------------------------------------------------
// tb_burst_length_estimator
// Self-checking bench for the hysteresis burst length estimator.
// ----------------------------------------------------------------------------
// A short table of directed transactions runs first: the empty-range begin
// run, the threshold edges, a burst left open across an end run, the spare
// opcodes and the sample extremes. Random runs follow: range samples, a
// begin run, run samples placed around the live thresholds, then an end run.
// Each configuration phase starts from an idle block. An in-bench model
// predicts every run summary, and popped summaries are compared field by
// field in order. Both sides insert random gaps; the receiver also holds off
// once for a long stretch so the input side backs up.
// ----------------------------------------------------------------------------
module tb_burst_length_estimator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_UNUSED_5 = 3'd5;
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    localparam logic [ble_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [ble_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

    localparam int SB = ble_pkg::SAMPLE_BITS;
    localparam int FB = ble_pkg::FRAC_BITS;

    localparam longint SAMPLE_HI = (longint'(1) <<< (SB - 1)) - 1;
    localparam longint SAMPLE_LO = -SAMPLE_HI - 1;
    localparam longint unsigned COUNT_MAX = (64'd1 << ble_pkg::COUNT_BITS) - 1;
    localparam longint unsigned MEAN_MAX = (64'd1 << ble_pkg::MEAN_BITS) - 1;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 250;
    localparam int ITEM_GOAL    = 1050;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_AT      = 6;
    localparam int HOLD_CYCLES  = 1000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [2:0]           opcode;
        logic signed [SB-1:0] sample;
        logic                 pinned;
        ble_pkg::out_item_t   result;
    } stim_row_t;

    localparam ble_pkg::out_item_t NO_PIN = '0;
    localparam int N_DIRECTED = 25;

    // pinned rows: summary right after reset, and after a full-scale range
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{ble_pkg::OP_END,   16'sd0,      1'b1, '{40'd0, 5'd0, 1'b1, 16'sh7fff, 16'sh8000}},
        '{OP_UNUSED_5,       16'sd1234,   1'b0, NO_PIN},
        '{OP_UNUSED_6,       16'shffff,   1'b0, NO_PIN},
        '{OP_UNUSED_7,       16'sh5a5a,   1'b0, NO_PIN},
        '{ble_pkg::OP_BEGIN, 16'sd0,      1'b0, NO_PIN},
        '{ble_pkg::OP_RUN,   16'sd0,      1'b0, NO_PIN},
        '{ble_pkg::OP_RUN,   16'sd0,      1'b0, NO_PIN},
        '{ble_pkg::OP_END,   16'sd0,      1'b0, NO_PIN},
        '{ble_pkg::OP_RANGE, 16'sh8000,   1'b0, NO_PIN},
        '{ble_pkg::OP_RANGE, 16'sh7fff,   1'b0, NO_PIN},
        '{ble_pkg::OP_BEGIN, 16'sd0,      1'b0, NO_PIN},
        '{ble_pkg::OP_END,   16'sd0,      1'b1, '{40'd0, 5'd0, 1'b1, 16'sh8000, 16'sh7fff}},
        '{ble_pkg::OP_RUN,   16'sh7fff,   1'b0, NO_PIN},
        '{ble_pkg::OP_RUN,   16'sd0,      1'b0, NO_PIN},
        '{ble_pkg::OP_RUN,   16'sd19661,  1'b0, NO_PIN},
        '{ble_pkg::OP_RUN,   16'sh8000,   1'b0, NO_PIN},
        '{ble_pkg::OP_RUN,   16'sd19660,  1'b0, NO_PIN},
        '{ble_pkg::OP_RUN,   16'sd19661,  1'b0, NO_PIN},
        '{ble_pkg::OP_RUN,   -16'sd19662, 1'b0, NO_PIN},
        '{ble_pkg::OP_RUN,   -16'sd19663, 1'b0, NO_PIN},
        '{ble_pkg::OP_RUN,   16'sd20000,  1'b0, NO_PIN},
        '{ble_pkg::OP_END,   16'sd0,      1'b0, NO_PIN},
        '{ble_pkg::OP_RUN,   16'sh8000,   1'b0, NO_PIN},
        '{ble_pkg::OP_CLEAR, 16'sd0,      1'b0, NO_PIN},
        '{ble_pkg::OP_END,   16'sd0,      1'b0, NO_PIN}
    };

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               push = 1'b0;
    logic                               full;
    ble_pkg::in_item_t                  in_item = '0;
    logic                               empty;
    logic                               pop = 1'b0;
    ble_pkg::out_item_t                 out_item;
    logic                               cfg_write = 1'b0;
    logic [ble_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [ble_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    // model state
    logic [FB-1:0]   frac_low = ble_pkg::LOW_FRACTION_RESET;
    logic [FB-1:0]   frac_high = ble_pkg::HIGH_FRACTION_RESET;
    longint          track_min = SAMPLE_HI;
    longint          track_max = SAMPLE_LO;
    longint          thr_low = 0;
    longint          thr_high = 0;
    bit              burst_open = 1'b0;
    longint unsigned open_len = 0;
    longint unsigned len_total = 0;
    longint unsigned bursts_closed = 0;

    ble_pkg::out_item_t expected_summaries[$];

    int items_sent = 0;
    int results_due = 0;
    int results_checked = 0;
    int mismatches = 0;
    int runs_capped = 0;
    int full_stalls = 0;
    int phases_run = 0;
    int send_streak = 0;
    int cycle_count = 0;

    burst_length_estimator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d summaries outstanding",
                 cycle_count, expected_summaries.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int draw_gap(inout int streak);
        if (streak > 0)
        begin
            streak--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            streak = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic longint threshold_at(input logic [FB-1:0] frac);
        longint prod;
        prod = longint'({48'd0, frac}) * (track_max - track_min);
        return track_min + (prod >>> 16);
    endfunction

    // advances the model by one transaction; returns 1 with a run summary
    function automatic bit burst_track(input ble_pkg::in_item_t item,
                                       output ble_pkg::out_item_t summary);
        longint          s;
        longint unsigned mean;
        s = longint'($signed(item.sample));
        summary = '0;
        case (item.opcode)
            ble_pkg::OP_RANGE:
            begin
                if (s > track_max)
                    track_max = s;
                if (s < track_min)
                    track_min = s;
            end
            ble_pkg::OP_BEGIN:
            begin
                thr_low = threshold_at(frac_low);
                thr_high = threshold_at(frac_high);
                burst_open = 1'b0;
                open_len = 0;
                len_total = 0;
                bursts_closed = 0;
            end
            ble_pkg::OP_RUN:
            begin
                if (bursts_closed < ble_pkg::MAX_BURSTS)
                begin
                    if (!burst_open && s > thr_high)
                    begin
                        burst_open = 1'b1;
                        open_len = 0;
                    end
                    else if (burst_open && s < thr_low)
                    begin
                        burst_open = 1'b0;
                        bursts_closed++;
                        if (bursts_closed == ble_pkg::MAX_BURSTS)
                            runs_capped++;
                        if (len_total > COUNT_MAX - open_len)
                            len_total = COUNT_MAX;
                        else
                            len_total += open_len;
                    end
                    if (burst_open && open_len < COUNT_MAX)
                        open_len++;
                end
            end
            ble_pkg::OP_END:
            begin
                mean = 0;
                if (bursts_closed != 0)
                begin
                    mean = (len_total << 8) / bursts_closed;
                    if (mean > MEAN_MAX)
                        mean = MEAN_MAX;
                end
                summary.mean_length = ble_pkg::MEAN_BITS'(mean);
                summary.burst_count = ble_pkg::BURST_BITS'(bursts_closed);
                summary.no_bursts = (bursts_closed == 0);
                summary.range_min = track_min[SB-1:0];
                summary.range_max = track_max[SB-1:0];
                return 1'b1;
            end
            ble_pkg::OP_CLEAR:
            begin
                track_min = SAMPLE_HI;
                track_max = SAMPLE_LO;
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    function automatic logic signed [SB-1:0] rand_in(input longint lo, input longint hi);
        longint a;
        longint b;
        a = (lo < SAMPLE_LO) ? SAMPLE_LO : lo;
        b = (hi > SAMPLE_HI) ? SAMPLE_HI : hi;
        if (a > b)
            return SB'($urandom);
        return SB'(a + longint'($urandom_range(int'(b - a))));
    endfunction

    // run sample placed relative to the live thresholds
    function automatic logic signed [SB-1:0] run_level(input bit strict,
                                                       input bit high_turn);
        int pick;
        pick = strict ? (high_turn ? 0 : 7) : $urandom_range(0, 19);
        if (pick < 7)
            return rand_in(thr_high + 1, SAMPLE_HI);
        if (pick < 14)
            return rand_in(SAMPLE_LO, thr_low - 1);
        if (pick == 14)
            return rand_in(thr_high, thr_high);
        if (pick == 15)
            return rand_in(thr_low, thr_low);
        if (pick < 18)
            return rand_in(thr_low, thr_high);
        return SB'($urandom);
    endfunction

    task automatic offer(input logic [2:0] opcode, input logic signed [SB-1:0] sample,
                         input bit pinned, input ble_pkg::out_item_t pinned_result);
        int                 gap;
        ble_pkg::in_item_t  item;
        ble_pkg::out_item_t summary;
        item.opcode = opcode;
        item.sample = sample;
        gap = draw_gap(send_streak);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        in_item <= item;
        do
        begin
            @(posedge clk);
            if (full)
                full_stalls++;
        end
        while (full);
        if (burst_track(item, summary))
        begin
            expected_summaries.insert(expected_summaries.size(),
                                      pinned ? pinned_result : summary);
            results_due++;
        end
        if (opcode <= ble_pkg::OP_CLEAR)
            items_sent++;
    endtask

    task automatic settle();
        push <= 1'b0;
        while (expected_summaries.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ble_pkg::CFG_INDEX_BITS-1:0] index,
                             input logic [ble_pkg::CFG_DATA_BITS-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        case (index)
            ble_pkg::REG_LOW_FRACTION:  frac_low = value;
            ble_pkg::REG_HIGH_FRACTION: frac_high = value;
            default:
            begin
            end
        endcase
    endtask

    task automatic emit_run();
        int     n_range;
        int     n_run;
        bit     strict;
        bit     high_turn;
        longint center;
        longint spread;
        if ($urandom_range(0, 3) == 0)
            offer(ble_pkg::OP_CLEAR, SB'($urandom), 1'b0, NO_PIN);
        if ($urandom_range(0, 7) == 0)
        begin
            offer(ble_pkg::OP_RANGE, SB'(SAMPLE_LO), 1'b0, NO_PIN);
            offer(ble_pkg::OP_RANGE, SB'(SAMPLE_HI), 1'b0, NO_PIN);
        end
        n_range = $urandom_range(0, 6);
        center = longint'($signed(SB'($urandom)));
        spread = $urandom_range(0, 6000);
        repeat (n_range)
            offer(ble_pkg::OP_RANGE, rand_in(center - spread, center + spread), 1'b0, NO_PIN);
        // occasionally skip the begin run so the previous run carries on
        if ($urandom_range(0, 7) != 0)
            offer(ble_pkg::OP_BEGIN, SB'($urandom), 1'b0, NO_PIN);
        strict = ($urandom_range(0, 3) == 0);
        n_run = ($urandom_range(0, 4) == 0) ? $urandom_range(45, 90) : $urandom_range(4, 30);
        high_turn = 1'b1;
        repeat (n_run)
        begin
            if ($urandom_range(0, 24) == 0)
                offer(3'($urandom_range(OP_UNUSED_7, OP_UNUSED_5)), SB'($urandom),
                      1'b0, NO_PIN);
            offer(ble_pkg::OP_RUN, run_level(strict, high_turn), 1'b0, NO_PIN);
            high_turn = !high_turn;
        end
        offer(ble_pkg::OP_END, SB'($urandom), 1'b0, NO_PIN);
    endtask

    task automatic check_result(input ble_pkg::out_item_t got);
        ble_pkg::out_item_t want;
        if (expected_summaries.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected summary: mean %0d count %0d none %0b min %0d max %0d",
                         got.mean_length, got.burst_count, got.no_bursts,
                         got.range_min, got.range_max);
        end
        else
        begin
            want = expected_summaries.pop_front();
            if (got.mean_length !== want.mean_length || got.burst_count !== want.burst_count ||
                got.no_bursts !== want.no_bursts || got.range_min !== want.range_min ||
                got.range_max !== want.range_max)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("summary %0d expected: mean %0d count %0d none %0b min %0d max %0d",
                             results_checked, want.mean_length, want.burst_count,
                             want.no_bursts, want.range_min, want.range_max);
                    $display("summary %0d actual:   mean %0d count %0d none %0b min %0d max %0d",
                             results_checked, got.mean_length, got.burst_count,
                             got.no_bursts, got.range_min, got.range_max);
                end
            end
        end
        results_checked++;
    endtask

    initial
    begin : summary_sink
        int gap;
        int streak;
        bit held;
        streak = 0;
        held = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held && results_checked == HOLD_AT)
            begin
                held = 1'b1;
                gap = HOLD_CYCLES;
            end
            else
                gap = draw_gap(streak);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            check_result(out_item);
        end
    end

    initial
    begin : stimulus
        int            phase_end;
        logic [FB-1:0] lo_frac;
        logic [FB-1:0] hi_frac;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            offer(DIRECTED_ROWS[i].opcode, DIRECTED_ROWS[i].sample,
                  DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].result);

        while (items_sent < ITEM_GOAL)
        begin
            settle();
            case (phases_run)
                0:
                begin
                    lo_frac = '0;
                    hi_frac = '1;
                end
                1:
                begin
                    lo_frac = '1;
                    hi_frac = '0;
                end
                2:
                begin
                    lo_frac = '1;
                    hi_frac = '1;
                end
                3:
                begin
                    lo_frac = '0;
                    hi_frac = '0;
                end
                default:
                begin
                    lo_frac = FB'($urandom);
                    hi_frac = FB'($urandom);
                end
            endcase
            write_reg(REG_SPARE_2, ble_pkg::CFG_DATA_BITS'($urandom));
            write_reg(ble_pkg::REG_LOW_FRACTION, lo_frac);
            write_reg(ble_pkg::REG_HIGH_FRACTION, hi_frac);
            write_reg(REG_SPARE_3, ble_pkg::CFG_DATA_BITS'($urandom));
            cfg_write <= 1'b0;
            phases_run++;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                emit_run();
        end
        settle();

        $display("Covered %0d transactions in %0d configuration phases, %0d of %0d summaries checked.",
                 items_sent, phases_run, results_checked, results_due);
        $display("%0d runs reached the burst cap; input held off by full for %0d cycles.",
                 runs_capped, full_stalls);
        if (mismatches == 0 && expected_summaries.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/ble_pkg.sv
sv/ble_cmd_fifo.sv
sv/ble_front.sv
sv/ble_div.sv
sv/ble_back.sv
sv/burst_length_estimator.sv
dv/tb_burst_length_estimator.sv
